FILE: rtl/rectangle_bisection_splitter_macros.svh
`ifndef RECTANGLE_BISECTION_SPLITTER_MACROS_SVH
`define RECTANGLE_BISECTION_SPLITTER_MACROS_SVH

// Assertion helpers: same-cycle implication and next-cycle implication.
`ifndef SYNTHESIS
`define RBS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define RBS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RBS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define RBS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

FILE: rtl/rbs_pkg.sv
package rbs_pkg;

    localparam int MAX_PIECES_DEF = 64;
    localparam int COORD_BITS_DEF = 16;
    localparam int CFG_W          = 7;

    // Control of the piece table ports.
    typedef struct packed {
        logic we;
        logic re;
    } t_mem_ctrl;

endpackage

FILE: rtl/rbs_if.sv
interface rbs_rect_if #(
    parameter int COORD_BITS = rbs_pkg::COORD_BITS_DEF
) ();
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] x_first;
    logic [COORD_BITS-1:0] y_first;
    logic [COORD_BITS-1:0] x_last;
    logic [COORD_BITS-1:0] y_last;

    modport source (output valid, x_first, y_first, x_last, y_last, input ready);
    modport sink   (input valid, x_first, y_first, x_last, y_last, output ready);
endinterface

interface rbs_piece_if #(
    parameter int COORD_BITS = rbs_pkg::COORD_BITS_DEF
) ();
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] piece_x_first;
    logic [COORD_BITS-1:0] piece_y_first;
    logic [COORD_BITS-1:0] piece_x_last;
    logic [COORD_BITS-1:0] piece_y_last;
    logic                  last;
    logic                  error;

    modport source (output valid, piece_x_first, piece_y_first, piece_x_last, piece_y_last,
                    last, error, input ready);
    modport sink   (input valid, piece_x_first, piece_y_first, piece_x_last, piece_y_last,
                    last, error, output ready);
endinterface

FILE: rtl/rbs_table.sv
module rbs_table #(
    parameter int DEPTH  = rbs_pkg::MAX_PIECES_DEF,
    parameter int DATA_W = 4 * rbs_pkg::COORD_BITS_DEF
) (
    input  logic                     i_clk,
    input  rbs_pkg::t_mem_ctrl       i_ctrl,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DATA_W-1:0]        i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DATA_W-1:0]        o_rdata
);
    import rbs_pkg::*;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read data holds until the next read is issued.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/rbs_cutter.sv
module rbs_cutter #(
    parameter int COORD_BITS = rbs_pkg::COORD_BITS_DEF
) (
    input  logic [4*COORD_BITS-1:0] i_piece,
    output logic                    o_split,
    output logic [4*COORD_BITS-1:0] o_first,
    output logic [4*COORD_BITS-1:0] o_second
);
    localparam int C = COORD_BITS;

    logic [C-1:0] x0, y0, x1, y1;
    logic [C-1:0] w, h;
    logic [C-1:0] x_mid, y_mid;

    assign x0 = i_piece[4*C-1:3*C];
    assign y0 = i_piece[3*C-1:2*C];
    assign x1 = i_piece[2*C-1:C];
    assign y1 = i_piece[C-1:0];

    assign w = x1 - x0;
    assign h = y1 - y0;
    // The first half keeps the extra pixel of an odd span.
    assign x_mid = x0 + (w >> 1);
    assign y_mid = y0 + (h >> 1);

    assign o_split = (w != '0) || (h != '0);

    always_comb begin
        if (w >= h) begin
            o_first  = {x0, y0, x_mid, y1};
            o_second = {x_mid + C'(1), y0, x1, y1};
        end else begin
            o_first  = {x0, y0, x1, y_mid};
            o_second = {x0, y_mid + C'(1), x1, y1};
        end
    end

endmodule

FILE: rtl/rectangle_bisection_splitter.sv
// A rejected rectangle gives a single error beat once its bounds and area are checked.
// A split into n pieces reads each entry in turn, skips single-pixel pieces and cuts the
// others, then reads out and emits the n pieces, each beat waiting while the output stalls.
// The piece table has a single write port (two writes per cut) and a registered read;
// one rectangle is worked at a time.
// Reset clears the control state and sets piece_count to 1; the table is not cleared.
`include "rectangle_bisection_splitter_macros.svh"

module rectangle_bisection_splitter #(
    parameter int MAX_PIECES = rbs_pkg::MAX_PIECES_DEF,
    parameter int COORD_BITS = rbs_pkg::COORD_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [rbs_pkg::CFG_W-1:0] i_cfg_wdata,
    rbs_rect_if.sink                  i_rect,
    rbs_piece_if.source               o_piece
);
    import rbs_pkg::*;

    localparam int C     = COORD_BITS;
    localparam int E_W   = 4 * C;
    localparam int IDX_W = $clog2(MAX_PIECES);
    localparam int CNT_W = $clog2(MAX_PIECES + 1);
    localparam int NW    = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int SW    = C + 1;
    localparam int CW    = (SW > CNT_W) ? SW : CNT_W;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_SPAN  = 9'b000000010,
        S_CHECK = 9'b000000100,
        S_ERR   = 9'b000001000,
        S_RD    = 9'b000010000,
        S_CUT   = 9'b000100000,
        S_WB    = 9'b001000000,
        S_ERD   = 9'b010000000,
        S_EOUT  = 9'b100000000
    } t_state;

    t_state             r_state, n_state;
    logic [CFG_W-1:0]   r_piece_count;
    logic [CNT_W-1:0]   r_n, n_n;
    logic [CNT_W-1:0]   r_pieces, n_pieces;
    logic [CNT_W-1:0]   r_pass_limit, n_pass_limit;
    logic [CNT_W-1:0]   r_scan, n_scan;
    logic [E_W-1:0]     r_rect, n_rect;
    logic [SW-1:0]      r_w, n_w;
    logic [SW-1:0]      r_h, n_h;
    logic               r_bad_bnd, n_bad_bnd;
    logic [E_W-1:0]     r_half_b, n_half_b;

    logic               r_out_valid, n_out_valid;
    logic [C-1:0]       r_out_x_first, r_out_y_first, r_out_x_last, r_out_y_last;
    logic [C-1:0]       n_out_x_first, n_out_y_first, n_out_x_last, n_out_y_last;
    logic               r_out_last, n_out_last;
    logic               r_out_error, n_out_error;

    logic [NW-1:0]      w_pc_ext;
    logic [CNT_W-1:0]   w_n_sat;
    logic [CW-1:0]      w_w_c, w_h_c, w_n_c;
    logic [2*CNT_W-1:0] w_area;
    logic               w_area_bad;
    logic               w_accept;
    logic               w_out_free;
    logic [CNT_W-1:0]   w_scan_inc;
    logic [CNT_W-1:0]   w_pieces_inc;

    t_mem_ctrl          w_mem_ctrl;
    logic [IDX_W-1:0]   w_waddr, w_raddr;
    logic [E_W-1:0]     w_wdata, w_rdata;
    logic               w_split;
    logic [E_W-1:0]     w_first, w_second;

    rbs_table #(
        .DEPTH  (MAX_PIECES),
        .DATA_W (E_W)
    ) u_table (
        .i_clk   (i_clk),
        .i_ctrl  (w_mem_ctrl),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    rbs_cutter #(
        .COORD_BITS (C)
    ) u_cutter (
        .i_piece  (w_rdata),
        .o_split  (w_split),
        .o_first  (w_first),
        .o_second (w_second)
    );

    // Zero pieces means one; anything above the table depth saturates.
    always_comb begin
        w_pc_ext = NW'(r_piece_count);
        if (w_pc_ext == '0) begin
            w_n_sat = CNT_W'(1);
        end else if (w_pc_ext > NW'(MAX_PIECES)) begin
            w_n_sat = CNT_W'(MAX_PIECES);
        end else begin
            w_n_sat = w_pc_ext[CNT_W-1:0];
        end
    end

    // Both spans are below the count before the product is used, so it stays narrow.
    assign w_w_c      = CW'(r_w);
    assign w_h_c      = CW'(r_h);
    assign w_n_c      = CW'(r_n);
    assign w_area     = w_w_c[CNT_W-1:0] * w_h_c[CNT_W-1:0];
    assign w_area_bad = (w_w_c < w_n_c) && (w_h_c < w_n_c) && (w_area < (2*CNT_W)'(r_n));

    assign w_accept     = i_rect.valid && i_rect.ready;
    assign w_out_free   = !r_out_valid || o_piece.ready;
    assign w_scan_inc   = r_scan + CNT_W'(1);
    assign w_pieces_inc = r_pieces + CNT_W'(1);

    assign i_rect.ready = (r_state == S_IDLE);

    always_comb begin
        n_state       = r_state;
        n_n           = r_n;
        n_pieces      = r_pieces;
        n_pass_limit  = r_pass_limit;
        n_scan        = r_scan;
        n_rect        = r_rect;
        n_w           = r_w;
        n_h           = r_h;
        n_bad_bnd     = r_bad_bnd;
        n_half_b      = r_half_b;
        n_out_valid   = r_out_valid && !o_piece.ready;
        n_out_x_first = r_out_x_first;
        n_out_y_first = r_out_y_first;
        n_out_x_last  = r_out_x_last;
        n_out_y_last  = r_out_y_last;
        n_out_last    = r_out_last;
        n_out_error   = r_out_error;
        w_mem_ctrl    = '0;
        w_waddr       = r_pieces[IDX_W-1:0];
        w_wdata       = r_half_b;
        w_raddr       = r_scan[IDX_W-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_rect  = {i_rect.x_first, i_rect.y_first, i_rect.x_last, i_rect.y_last};
                    n_n     = w_n_sat;
                    n_state = S_SPAN;
                end
            end
            S_SPAN: begin
                n_bad_bnd = (r_rect[2*C-1:C] < r_rect[4*C-1:3*C])
                         || (r_rect[C-1:0] < r_rect[3*C-1:2*C]);
                n_w       = SW'(r_rect[2*C-1:C]) - SW'(r_rect[4*C-1:3*C]) + SW'(1);
                n_h       = SW'(r_rect[C-1:0]) - SW'(r_rect[3*C-1:2*C]) + SW'(1);
                n_state   = S_CHECK;
            end
            S_CHECK: begin
                if (r_bad_bnd || w_area_bad) begin
                    n_state = S_ERR;
                end else begin
                    w_mem_ctrl.we = 1'b1;
                    w_waddr       = '0;
                    w_wdata       = r_rect;
                    n_pieces      = CNT_W'(1);
                    n_pass_limit  = CNT_W'(1);
                    n_scan        = '0;
                    n_state       = (r_n == CNT_W'(1)) ? S_ERD : S_RD;
                end
            end
            S_ERR: begin
                if (w_out_free) begin
                    n_out_valid   = 1'b1;
                    n_out_x_first = '0;
                    n_out_y_first = '0;
                    n_out_x_last  = '0;
                    n_out_y_last  = '0;
                    n_out_last    = 1'b1;
                    n_out_error   = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            S_RD: begin
                w_mem_ctrl.re = 1'b1;
                n_state       = S_CUT;
            end
            S_CUT: begin
                if (w_split) begin
                    w_mem_ctrl.we = 1'b1;
                    w_waddr       = r_scan[IDX_W-1:0];
                    w_wdata       = w_first;
                    n_half_b      = w_second;
                    n_state       = S_WB;
                end else begin
                    // A single pixel stays as it is; move on to the next entry.
                    if (w_scan_inc == r_pass_limit) begin
                        n_scan       = '0;
                        n_pass_limit = r_pieces;
                    end else begin
                        n_scan = w_scan_inc;
                    end
                    n_state = S_RD;
                end
            end
            S_WB: begin
                w_mem_ctrl.we = 1'b1;
                n_pieces      = w_pieces_inc;
                if (w_pieces_inc == r_n) begin
                    n_scan  = '0;
                    n_state = S_ERD;
                end else begin
                    if (w_scan_inc == r_pass_limit) begin
                        n_scan       = '0;
                        n_pass_limit = w_pieces_inc;
                    end else begin
                        n_scan = w_scan_inc;
                    end
                    n_state = S_RD;
                end
            end
            S_ERD: begin
                w_mem_ctrl.re = 1'b1;
                n_state       = S_EOUT;
            end
            S_EOUT: begin
                if (w_out_free) begin
                    n_out_valid   = 1'b1;
                    n_out_x_first = w_rdata[4*C-1:3*C];
                    n_out_y_first = w_rdata[3*C-1:2*C];
                    n_out_x_last  = w_rdata[2*C-1:C];
                    n_out_y_last  = w_rdata[C-1:0];
                    n_out_last    = (w_scan_inc == r_pieces);
                    n_out_error   = 1'b0;
                    n_scan        = w_scan_inc;
                    n_state       = (w_scan_inc == r_pieces) ? S_IDLE : S_ERD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_piece_count <= CFG_W'(1);
            r_n           <= CNT_W'(1);
            r_pieces      <= '0;
            r_pass_limit  <= '0;
            r_scan        <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_n          <= n_n;
            r_pieces     <= n_pieces;
            r_pass_limit <= n_pass_limit;
            r_scan       <= n_scan;
            r_out_valid  <= n_out_valid;
            if (i_cfg_we) begin
                r_piece_count <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rect        <= n_rect;
        r_w           <= n_w;
        r_h           <= n_h;
        r_bad_bnd     <= n_bad_bnd;
        r_half_b      <= n_half_b;
        r_out_x_first <= n_out_x_first;
        r_out_y_first <= n_out_y_first;
        r_out_x_last  <= n_out_x_last;
        r_out_y_last  <= n_out_y_last;
        r_out_last    <= n_out_last;
        r_out_error   <= n_out_error;
    end

    assign o_piece.valid         = r_out_valid;
    assign o_piece.piece_x_first = r_out_x_first;
    assign o_piece.piece_y_first = r_out_y_first;
    assign o_piece.piece_x_last  = r_out_x_last;
    assign o_piece.piece_y_last  = r_out_y_last;
    assign o_piece.last          = r_out_last;
    assign o_piece.error         = r_out_error;

    // The piece count is only meaningful once the table has been seeded.
    `RBS_ASSERT_IMP(a_pieces_in_range, i_clk, i_rst_n,
        (r_state == S_RD) || (r_state == S_CUT) || (r_state == S_WB)
            || (r_state == S_ERD) || (r_state == S_EOUT),
        r_pieces <= r_n, "piece count passed the target")
    `RBS_ASSERT_IMP(a_scan_in_pass, i_clk, i_rst_n,
        r_state == S_RD, r_scan < r_pass_limit, "scan index beyond the current pass")
    `RBS_ASSERT_IMP(a_error_is_last, i_clk, i_rst_n,
        r_out_valid && r_out_error,
        r_out_last && (r_out_x_first == '0) && (r_out_y_last == '0),
        "error beat is not a lone zeroed last beat")
    `RBS_ASSERT_NXT(a_one_at_a_time, i_clk, i_rst_n,
        w_accept, !i_rect.ready, "input taken while a rectangle is in work")

endmodule
